FILE: sv/etfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame parser package
// Shared constants, codes and types for the telemetry frame parser.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int FRAME_BYTES_MAX_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int KIND_W     = 2;
    localparam int SPEED_W    = 26;
    localparam int VOLT_W     = 17;
    localparam int CENTI_W    = 16;
    localparam int DIVISOR_W  = 16;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0]    HDR_SHORT   = 8'h9B;
    localparam logic [BYTE_W-1:0]    HDR_LONG    = 8'hB9;
    localparam logic [SPEED_W-1:0]   SPEED_NUM   = 26'd60000000;
    localparam logic [DIVISOR_W-1:0] VOLT_DIV    = 16'd89;
    localparam logic [6:0]           VOLT_MUL    = 7'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd150;

    localparam logic [LEN_W-1:0] LEN_OLD   = 7'd9;
    localparam logic [LEN_W-1:0] LEN_SHORT = 7'd18;
    localparam logic [LEN_W-1:0] LEN_LONG  = 7'd32;

    localparam logic [KIND_W-1:0] KIND_OLD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SPEED_W-1:0] speed;
        logic [VOLT_W-1:0]  volt;
        logic [CENTI_W-1:0] cur;
        logic [CENTI_W-1:0] temp1;
        logic [CENTI_W-1:0] temp2;
    } t_result;

    typedef struct packed {
        logic                 start;
        logic [SPEED_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SPEED_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: sv/etfp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame parser channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface etfp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [etfp_pkg::BYTE_W-1:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink (input valid, input req_type, input byte_value, output ready);
endinterface

interface etfp_out_if;
    logic                         valid;
    logic                         ready;
    logic [etfp_pkg::KIND_W-1:0]  frame_kind;
    logic [etfp_pkg::SPEED_W-1:0] speed_rpm;
    logic [etfp_pkg::VOLT_W-1:0]  voltage_centi;
    logic [etfp_pkg::CENTI_W-1:0] current_centi;
    logic [etfp_pkg::CENTI_W-1:0] temp_first_centi;
    logic [etfp_pkg::CENTI_W-1:0] temp_second_centi;

    modport source (output valid, output frame_kind, output speed_rpm, output voltage_centi,
                    output current_centi, output temp_first_centi,
                    output temp_second_centi, input ready);
    modport sink (input valid, input frame_kind, input speed_rpm, input voltage_centi,
                  input current_centi, input temp_first_centi,
                  input temp_second_centi, output ready);
endinterface
`default_nettype wire

FILE: sv/etfp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etfp_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  etfp_pkg::t_div_req i_req,
    output etfp_pkg::t_div_rsp o_rsp
);

    localparam int Q_W   = etfp_pkg::SPEED_W;
    localparam int D_W   = etfp_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [D_W-1:0]   r_div;

    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           qbit;
    logic [D_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[Q_W-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
        n_rem = qbit ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-2:0], qbit};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_busy && (r_cnt == LAST);
    assign o_rsp.quotient = {r_quo[Q_W-2:0], qbit};

endmodule
`default_nettype wire

FILE: sv/esc_telemetry_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame parser
// Hunts for frame headers in a serial byte stream, collects and validates
// frames, and reports speed, voltage, current, temperatures and timeouts.
// ----------------------------------------------------------------------------
// Items that give no result are taken one per cycle; a result waiting for the
// output holds off the input. A tick timeout, a long frame or a zero-period old
// frame is registered as a result and then moved to the output register. Other
// old frames and short frames first pass through the serial divider, and no item
// is taken until their result has gone to the output register. Reset is synchronous;
// it clears the parser, timer and output and restores old format with a 150 ms timeout.
module esc_telemetry_frame_parser #(
    parameter int FRAME_BYTES_MAX = etfp_pkg::FRAME_BYTES_MAX_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    etfp_in_if.sink                            i_in,
    etfp_out_if.source                         o_res,
    input  wire                                i_cfg_we,
    input  wire [etfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [etfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int   CNT_W   = $clog2(FRAME_BYTES_MAX + 1);
    localparam int   WIN_W   = 10 * etfp_pkg::BYTE_W;
    localparam logic LONG_OK = (FRAME_BYTES_MAX >= 32);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_OLD   = 2'd1;
    localparam logic [1:0] PH_SHORT = 2'd2;
    localparam logic [1:0] PH_LONG  = 2'd3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [1:0]                         r_phase, n_phase;
    logic [CNT_W-1:0]                   r_count, n_count;
    logic [etfp_pkg::BYTE_W-1:0]        r_first, n_first;
    logic                               r_ok, n_ok;
    logic [WIN_W-1:0]                   r_win, n_win;
    logic                               r_active, n_active;
    logic [etfp_pkg::TIMEOUT_W-1:0]     r_ms, n_ms;
    logic                               r_mode, n_mode;
    logic [etfp_pkg::TIMEOUT_W-1:0]     r_timeout, n_timeout;
    etfp_pkg::t_result                  r_res, n_res;
    etfp_pkg::t_result                  r_out, n_out;
    logic                               r_out_valid, n_out_valid;

    etfp_pkg::t_div_req                 div_req;
    etfp_pkg::t_div_rsp                 div_rsp;

    logic                               in_fire;
    logic [WIN_W+etfp_pkg::BYTE_W-1:0]  window;
    logic [etfp_pkg::TIMEOUT_W-1:0]     ms_inc;
    logic [CNT_W-1:0]                   count_inc;
    logic [etfp_pkg::LEN_W-1:0]         frame_len;
    logic                               ok_now;
    logic [22:0]                        volt_x100;

    etfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign window     = {r_win, i_in.byte_value};
    assign ms_inc     = (r_ms != '1) ? r_ms + 1'b1 : r_ms;
    assign count_inc  = r_count + 1'b1;
    assign volt_x100  = {7'd0, window[63:48]} * {16'd0, etfp_pkg::VOLT_MUL};
    assign ok_now     = r_ok && !(((r_count == CNT_W'(3)) || (r_count == CNT_W'(5)))
                                  && (i_in.byte_value != '0));

    always_comb begin
        case (r_phase)
            PH_OLD:   frame_len = etfp_pkg::LEN_OLD;
            PH_SHORT: frame_len = etfp_pkg::LEN_SHORT;
            PH_LONG:  frame_len = etfp_pkg::LEN_LONG;
            default:  frame_len = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_first     = r_first;
        n_ok        = r_ok;
        n_win       = r_win;
        n_active    = r_active;
        n_ms        = r_ms;
        n_mode      = r_mode;
        n_timeout   = r_timeout;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_req     = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                etfp_pkg::CFG_PROTOCOL_MODE: n_mode = i_cfg_data[0];
                etfp_pkg::CFG_TIMEOUT_MS:    n_timeout = i_cfg_data;
                default: ;
            endcase
        end

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.req_type) begin
                        n_ms = ms_inc;
                        if (!r_mode && r_active && (ms_inc > r_timeout)) begin
                            n_active   = 1'b0;
                            n_res      = '0;
                            n_res.kind = etfp_pkg::KIND_TIMEOUT;
                            n_state    = ST_EMIT;
                        end
                    end else if (r_phase == PH_HUNT) begin
                        n_count = '0;
                        n_ok    = 1'b1;
                        if (i_in.byte_value == etfp_pkg::HDR_SHORT) begin
                            n_phase = r_mode ? PH_SHORT : PH_OLD;
                        end else if (r_mode && LONG_OK
                                     && (i_in.byte_value == etfp_pkg::HDR_LONG)) begin
                            n_phase = PH_LONG;
                        end
                    end else begin
                        n_win = window[WIN_W-1:0];
                        n_ok  = ok_now;
                        if (r_count == '0) begin
                            n_first = i_in.byte_value;
                        end
                        if (etfp_pkg::LEN_W'(count_inc) == frame_len) begin
                            n_phase = PH_HUNT;
                            n_count = '0;
                            n_res   = '0;
                            case (r_phase)
                                PH_OLD: begin
                                    if (ok_now) begin
                                        n_active   = 1'b1;
                                        n_ms       = '0;
                                        n_res.kind = etfp_pkg::KIND_OLD;
                                        if (window[15:0] == '0) begin
                                            n_res.speed = etfp_pkg::SPEED_NUM;
                                            n_state     = ST_EMIT;
                                        end else begin
                                            div_req.start    = 1'b1;
                                            div_req.dividend = etfp_pkg::SPEED_NUM;
                                            div_req.divisor  = window[15:0];
                                            n_state          = ST_DIV;
                                        end
                                    end
                                end
                                PH_SHORT: begin
                                    if (r_first != etfp_pkg::HDR_SHORT) begin
                                        n_active         = (window[87:64] != '0);
                                        n_res.kind       = etfp_pkg::KIND_SHORT;
                                        n_res.speed      = {2'd0, window[87:64]};
                                        n_res.cur        = window[47:32];
                                        n_res.temp1      = window[31:16];
                                        n_res.temp2      = window[15:0];
                                        div_req.start    = 1'b1;
                                        div_req.dividend = {3'd0, volt_x100};
                                        div_req.divisor  = etfp_pkg::VOLT_DIV;
                                        n_state          = ST_DIV;
                                    end
                                end
                                PH_LONG: begin
                                    if (r_first == etfp_pkg::HDR_SHORT) begin
                                        n_active    = (window[87:64] != '0);
                                        n_res.kind  = etfp_pkg::KIND_LONG;
                                        n_res.speed = {2'd0, window[87:64]};
                                        n_res.volt  = {1'b0, window[63:48]};
                                        n_res.cur   = window[47:32];
                                        n_res.temp1 = window[31:16];
                                        n_res.temp2 = window[15:0];
                                        n_state     = ST_EMIT;
                                    end
                                end
                                default: ;
                            endcase
                        end else begin
                            n_count = count_inc;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (r_res.kind == etfp_pkg::KIND_OLD) begin
                        n_res.speed = div_rsp.quotient;
                    end else begin
                        n_res.volt = div_rsp.quotient[etfp_pkg::VOLT_W-1:0];
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_ok        <= 1'b1;
            r_active    <= 1'b0;
            r_ms        <= '0;
            r_mode      <= 1'b0;
            r_timeout   <= etfp_pkg::TIMEOUT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_ok        <= n_ok;
            r_active    <= n_active;
            r_ms        <= n_ms;
            r_mode      <= n_mode;
            r_timeout   <= n_timeout;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_win   <= n_win;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.frame_kind        = r_out.kind;
    assign o_res.speed_rpm         = r_out.speed;
    assign o_res.voltage_centi     = r_out.volt;
    assign o_res.current_centi     = r_out.cur;
    assign o_res.temp_first_centi  = r_out.temp1;
    assign o_res.temp_second_centi = r_out.temp2;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> div_rsp.busy)
        else $error("waiting on an idle divider");

    a_tick_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.req_type) |=> (r_state != ST_DIV))
        else $error("tick transfer started a division");

    a_old_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.frame_kind == etfp_pkg::KIND_OLD)) |-> (o_res.speed_rpm != '0))
        else $error("old frame reported zero speed");

endmodule
`default_nettype wire
